// ===== design/ipe_pkg.sv =====
`timescale 1ns / 1ps
package ipe_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COUNT_W      = 13;
  localparam int PHASE_W      = COUNT_W + 1;
  localparam int PROD_W       = SAMPLE_W + COUNT_W;
  localparam int DIV_CNT_W    = $clog2(SAMPLE_W);
  localparam int RESULT_CNT_W = 7;

  localparam logic [COUNT_W-1:0]      MAX_BINS    = 13'd4096;
  localparam logic [SAMPLE_W-1:0]     SAMPLE_MAX  = 16'hFFFF;
  localparam logic [RESULT_CNT_W-1:0] MAX_RESULTS = 7'd64;

  // Configuration register indexes
  localparam logic REG_IN_COUNT  = 1'b0;
  localparam logic REG_OUT_COUNT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;           // latch a new sample word
    logic div_start;      // start the scaled divider
    logic div_part;       // divider multiplies by phase instead of in_count
    logic share_load;     // store the quotient as the equal share
    logic straddle_emit;  // close the bin that straddles two input bins
    logic step;           // one step of the phase loop
    logic tail_step;      // one repeated share at the end of a frame
    logic finish;         // flush the held word as the last one of the sample
  } ipe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic straddle;
    logic final_in;
    logic loop_end;
    logic tail_over;
    logic out_free;
    logic pend_valid;
  } ipe_stat_t;

  // Clamp a bin count into 1..MAX_BINS
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v == '0) r = COUNT_W'(1);
    else if (v > MAX_BINS) r = MAX_BINS;
    return r;
  endfunction

endpackage

// ===== design/ipe_div.sv =====
`timescale 1ns / 1ps
module ipe_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ipe_pkg::SAMPLE_W-1:0] dividend_a,
  input  logic [ipe_pkg::COUNT_W-1:0]  mult_b,
  input  logic [ipe_pkg::COUNT_W-1:0]  divisor,
  output logic [ipe_pkg::SAMPLE_W-1:0] quotient,
  output logic                         done
);
  import ipe_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_LOAD, D_RUN, D_DONE} div_state_t;

  div_state_t           state;
  logic [PROD_W-1:0]    prod;
  logic [COUNT_W-1:0]   divisor_r;
  logic [COUNT_W-1:0]   rem;
  logic [SAMPLE_W-1:0]  q;
  logic                 sat;
  logic [DIV_CNT_W-1:0] cnt;

  logic [COUNT_W:0]     rem_shift;
  logic [COUNT_W:0]     rem_sub;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem, q[SAMPLE_W-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor_r};
  assign fits      = rem_shift >= {1'b0, divisor_r};

  assign done     = (state == D_DONE);
  assign quotient = sat ? SAMPLE_MAX : q;

  // Multiply, load the high half, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            prod      <= PROD_W'(dividend_a) * PROD_W'(mult_b);
            divisor_r <= divisor;
            state     <= D_LOAD;
          end
        end
        D_LOAD: begin
          rem   <= prod[PROD_W-1:SAMPLE_W];
          q     <= prod[SAMPLE_W-1:0];
          sat   <= prod[PROD_W-1:SAMPLE_W] >= divisor_r;
          cnt   <= '0;
          state <= D_RUN;
        end
        D_RUN: begin
          rem <= fits ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
          q   <= {q[SAMPLE_W-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(SAMPLE_W - 1)) state <= D_DONE;
        end
        D_DONE: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/ipe_datapath.sv =====
`timescale 1ns / 1ps
module ipe_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [ipe_pkg::COUNT_W-1:0]  cfg_data,
  input  logic [ipe_pkg::SAMPLE_W-1:0] sample_value,
  input  ipe_pkg::ipe_cmd_t            cmd,
  output ipe_pkg::ipe_stat_t           stat,
  output logic [ipe_pkg::SAMPLE_W-1:0] bin_value,
  output logic                         run_last,
  output logic                         frame_done,
  output logic                         bin_valid,
  input  logic                         bin_ready
);
  import ipe_pkg::*;

  // Configuration
  logic [COUNT_W-1:0] in_count;
  logic [COUNT_W-1:0] out_count;
  logic [COUNT_W-1:0] ic;
  logic [COUNT_W-1:0] oc_clamped;
  logic [COUNT_W-1:0] oc;

  // Frame state
  logic [SAMPLE_W-1:0]       sample_hold;
  logic [SAMPLE_W-1:0]       share_size;
  logic [SAMPLE_W-1:0]       remaining_count;
  logic [SAMPLE_W-1:0]       old_rest;
  logic signed [PHASE_W-1:0] phase_accumulator;
  logic [COUNT_W-1:0]        outputs_emitted;
  logic [COUNT_W-1:0]        inputs_taken;
  logic                      straddle_pending;
  logic [RESULT_CNT_W-1:0]   result_cnt;
  logic [SAMPLE_W-1:0]       pend_value;
  logic                      pend_valid;

  // Arithmetic
  logic [SAMPLE_W-1:0]       quotient;
  logic                      div_done;
  logic [COUNT_W-1:0]        div_b;
  logic signed [PHASE_W-1:0] phase_step;
  logic signed [PHASE_W-1:0] phase_wrap;
  logic signed [PHASE_W-1:0] phase_back;
  logic [SAMPLE_W:0]         sum_wide;
  logic [SAMPLE_W-1:0]       straddle_sum;
  logic [SAMPLE_W-1:0]       part_rest;
  logic [SAMPLE_W-1:0]       share_rest;
  logic                      final_in;
  logic                      room;
  logic                      emit_req;
  logic [SAMPLE_W-1:0]       emit_val;
  logic                      push_word;

  assign ic         = clamp_count(in_count);
  assign oc_clamped = clamp_count(out_count);
  assign oc         = (ic > oc_clamped) ? ic : oc_clamped;

  // Share uses in_count, the straddle part uses the positive phase
  assign div_b = cmd.div_part ? phase_accumulator[COUNT_W-1:0] : ic;

  ipe_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .dividend_a (sample_hold),
    .mult_b     (div_b),
    .divisor    (oc),
    .quotient   (quotient),
    .done       (div_done)
  );

  assign phase_step = phase_accumulator + $signed({1'b0, ic});
  assign phase_wrap = phase_step - $signed({1'b0, oc});
  assign phase_back = phase_accumulator - $signed({1'b0, oc});

  // Saturate the straddle sum, floor the rests at zero
  assign sum_wide     = {1'b0, old_rest} + {1'b0, quotient};
  assign straddle_sum = sum_wide[SAMPLE_W] ? SAMPLE_MAX : sum_wide[SAMPLE_W-1:0];
  assign part_rest    = (sample_hold > quotient) ? sample_hold - quotient : '0;
  assign share_rest   = (remaining_count > share_size) ? remaining_count - share_size : '0;

  assign final_in = inputs_taken >= ic;
  assign room     = result_cnt < MAX_RESULTS;

  // Pick the value of the bin produced this cycle
  always_comb begin
    emit_req = 1'b0;
    emit_val = share_size;
    if (cmd.straddle_emit) begin
      emit_req = 1'b1;
      emit_val = straddle_sum;
    end else if (cmd.step) begin
      if (phase_step[PHASE_W-1]) begin
        emit_req = 1'b1;
      end else if (phase_step == '0) begin
        emit_req = 1'b1;
        emit_val = remaining_count;
      end
    end else if (cmd.tail_step) begin
      emit_req = 1'b1;
    end
  end

  // Move the held word out when a newer one replaces it or the sample ends
  assign push_word = pend_valid && ((emit_req && room) || cmd.finish);

  assign stat.div_done   = div_done;
  assign stat.straddle   = straddle_pending;
  assign stat.final_in   = final_in;
  assign stat.loop_end   = !phase_step[PHASE_W-1];
  assign stat.tail_over  = (outputs_emitted >= oc) || !room;
  assign stat.out_free   = !bin_valid || bin_ready;
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count         <= MAX_BINS;
      out_count        <= MAX_BINS;
      inputs_taken     <= '0;
      straddle_pending <= 1'b0;
      result_cnt       <= '0;
      pend_valid       <= 1'b0;
      bin_valid        <= 1'b0;
    end else begin
      // Register write ends the frame in progress
      if (cfg_write) begin
        if (cfg_index == REG_IN_COUNT) begin
          in_count <= cfg_data;
        end else if (cfg_index == REG_OUT_COUNT) begin
          out_count <= cfg_data;
        end
        inputs_taken     <= '0;
        straddle_pending <= 1'b0;
      end

      // Latch a new sample, start a frame on the first one
      if (cmd.take) begin
        sample_hold     <= sample_value;
        old_rest        <= remaining_count;
        remaining_count <= sample_value;
        inputs_taken    <= inputs_taken + 1'b1;
        result_cnt      <= '0;
        if (inputs_taken == '0) begin
          phase_accumulator <= -$signed({1'b0, oc});
          outputs_emitted   <= '0;
          straddle_pending  <= 1'b0;
        end
      end

      if (cmd.share_load) begin
        share_size <= quotient;
      end

      // Close the straddling bin
      if (cmd.straddle_emit) begin
        remaining_count   <= part_rest;
        phase_accumulator <= phase_back;
        straddle_pending  <= 1'b0;
      end

      // Advance the phase by one output bin
      if (cmd.step) begin
        if (phase_step[PHASE_W-1]) begin
          remaining_count   <= share_rest;
          phase_accumulator <= phase_step;
        end else if (phase_step == '0) begin
          phase_accumulator <= phase_wrap;
        end else begin
          phase_accumulator <= phase_step;
          straddle_pending  <= 1'b1;
        end
      end

      // Count every bin, hold only those under the result cap
      if (emit_req) begin
        outputs_emitted <= outputs_emitted + 1'b1;
        if (room) begin
          pend_value <= emit_val;
          pend_valid <= 1'b1;
          result_cnt <= result_cnt + 1'b1;
        end
      end

      if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (final_in) begin
          inputs_taken     <= '0;
          straddle_pending <= 1'b0;
        end
      end

      // Output register
      if (push_word) begin
        bin_valid  <= 1'b1;
        bin_value  <= pend_value;
        run_last   <= cmd.finish;
        frame_done <= cmd.finish && final_in;
      end else if (bin_ready) begin
        bin_valid <= 1'b0;
      end
    end
  end

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    result_cnt <= MAX_RESULTS)
    else $error("more words held for one sample than the cap allows");

  a_straddle_phase: assert property (@(posedge clk) disable iff (rst)
    straddle_pending |-> (!phase_accumulator[PHASE_W-1] && phase_accumulator != '0))
    else $error("straddle pending without a positive phase");

  a_inputs_bound: assert property (@(posedge clk) disable iff (rst)
    inputs_taken <= ic)
    else $error("sample count ran past in_count");

endmodule

// ===== design/ipe_ctrl.sv =====
`timescale 1ns / 1ps
module ipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  ipe_pkg::ipe_stat_t stat,
  output ipe_pkg::ipe_cmd_t  cmd
);
  import ipe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHARE_GO,
    S_SHARE_WAIT,
    S_PART_GO,
    S_PART_WAIT,
    S_STRADDLE,
    S_LOOP,
    S_TAIL,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Sequence one sample: share division, optional straddle, bins, flush
  always_comb begin
    cmd          = '0;
    state_next   = state;
    sample_ready = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.take   = 1'b1;
          state_next = S_SHARE_GO;
        end
      end
      S_SHARE_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_SHARE_WAIT;
      end
      S_SHARE_WAIT: begin
        if (stat.div_done) begin
          cmd.share_load = 1'b1;
          if (stat.straddle) state_next = S_PART_GO;
          else if (stat.final_in) state_next = S_TAIL;
          else state_next = S_LOOP;
        end
      end
      S_PART_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_part  = 1'b1;
        state_next    = S_PART_WAIT;
      end
      S_PART_WAIT: begin
        if (stat.div_done) state_next = S_STRADDLE;
      end
      S_STRADDLE: begin
        if (stat.out_free) begin
          cmd.straddle_emit = 1'b1;
          state_next        = stat.final_in ? S_TAIL : S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.loop_end) state_next = S_FINISH;
        end
      end
      S_TAIL: begin
        if (stat.tail_over) state_next = S_FINISH;
        else if (stat.out_free) cmd.tail_step = 1'b1;
      end
      S_FINISH: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    sample_ready |-> !stat.pend_valid)
    else $error("word left held while waiting for a new sample");

  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_SHARE_WAIT || state == S_PART_WAIT))
    else $error("divider finished while the controller was not waiting");

endmodule

// ===== design/integral_preserving_expander.sv =====
`timescale 1ns / 1ps
// Histogram rebinning with the total count kept: a frame of in_count sample
// words is spread over out_count bin words (out_count >= in_count).
// Sample channel: sample_value with sample_valid / sample_ready, one count per word.
// Bin channel: bin_value, run_last, frame_done with bin_valid / bin_ready.
// run_last marks the last bin word caused by a sample, frame_done the last one
// of the frame. At most 64 bin words follow one sample; extra bins are dropped.
// Config: cfg_write, cfg_index (0 in_count, 1 out_count), cfg_data; a write
// ends the frame in progress. Both counts reset to 4096.
// Timing: one sample at a time. Each sample is accepted, then divided for its
// share (one multiply, one load, 16 quotient bits in the shared serial
// divider), divided again when a bin straddles two samples, then gives one bin
// per cycle while the output register is free, plus one flush step.
// The bin output register lets the block keep working while a word waits;
// when the receiver stalls, bin production stops until the register drains.
// Reset (rst, synchronous) empties the output and starts a fresh frame.
module integral_preserving_expander (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [ipe_pkg::COUNT_W-1:0]  cfg_data,
  input  logic [ipe_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  output logic [ipe_pkg::SAMPLE_W-1:0] bin_value,
  output logic                         run_last,
  output logic                         frame_done,
  output logic                         bin_valid,
  input  logic                         bin_ready
);
  import ipe_pkg::*;

  ipe_cmd_t  cmd;
  ipe_stat_t stat;

  ipe_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  ipe_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_value (sample_value),
    .cmd          (cmd),
    .stat         (stat),
    .bin_value    (bin_value),
    .run_last     (run_last),
    .frame_done   (frame_done),
    .bin_valid    (bin_valid),
    .bin_ready    (bin_ready)
  );

endmodule
